@@ rtl/bbt_pkg.sv @@
// Shared constants and types of the bounding box tracker.
`default_nettype none

package bbt_pkg;

  // Number of coordinate axes of a point.
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned AXIS_IDX_W = $clog2(NUM_AXES);
  localparam int unsigned AXIS_CNT_W = $clog2(NUM_AXES + 1);

  // Depth of the box queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Fill status of the box queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ rtl/bbt_if.sv @@
// Point and result channel interfaces of the bounding box tracker.
`default_nettype none

interface bbt_point_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         last_point;

  modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface bbt_result_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic        [COORD_BITS-1:0] extent_x;
  logic        [COORD_BITS-1:0] extent_y;
  logic        [COORD_BITS-1:0] extent_z;
  logic        [COORD_BITS:0]   diagonal;

  modport source (output valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
                  diagonal, input ready);
  modport sink   (input valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
                  diagonal, output ready);
endinterface

`default_nettype wire

@@ rtl/bbt_front.sv @@
// Front of the tracker: running per-axis minimum and maximum of the points.
`default_nettype none

module bbt_front
  import bbt_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 pt_valid_i,
  output logic                                      pt_ready_o,
  input  wire logic [NUM_AXES*COORD_BITS-1:0]       pt_coord_i,
  input  wire logic                                 pt_last_i,
  input  wire q_status_t                            q_stat_i,
  output logic                                      push_o,
  output logic      [2*NUM_AXES*COORD_BITS-1:0]     box_o
);

  logic signed [COORD_BITS-1:0] low_q  [NUM_AXES];
  logic signed [COORD_BITS-1:0] high_q [NUM_AXES];
  logic signed [COORD_BITS-1:0] low_d  [NUM_AXES];
  logic signed [COORD_BITS-1:0] high_d [NUM_AXES];
  logic                         empty_q;
  logic                         accept;

  // A closing point needs a free queue slot; holding all points back while the
  // queue is full keeps the rule simple.
  assign pt_ready_o = ~q_stat_i.full;
  assign accept     = pt_valid_i & pt_ready_o;
  assign push_o     = accept & pt_last_i;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [COORD_BITS-1:0] p;
      p = $signed(pt_coord_i[a*COORD_BITS +: COORD_BITS]);
      if (empty_q) begin
        low_d[a]  = p;
        high_d[a] = p;
      end else begin
        low_d[a]  = (p < low_q[a])  ? p : low_q[a];
        high_d[a] = (p > high_q[a]) ? p : high_q[a];
      end
      box_o[a*COORD_BITS +: COORD_BITS]              = low_d[a];
      box_o[(NUM_AXES+a)*COORD_BITS +: COORD_BITS]   = high_d[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        low_q[a]  <= '0;
        high_q[a] <= '0;
      end
    end else if (accept) begin
      if (pt_last_i) begin
        empty_q <= 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
          low_q[a]  <= '0;
          high_q[a] <= '0;
        end
      end else begin
        empty_q <= 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
          low_q[a]  <= low_d[a];
          high_q[a] <= high_d[a];
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bbt_queue.sv @@
// Short queue of finished boxes between the front and the back.
`default_nettype none

module bbt_queue
  import bbt_pkg::*;
#(
  parameter int unsigned WIDTH = 144
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output q_status_t             stat_o
);

  logic [WIDTH-1:0]   mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic [Q_CNT_W-1:0] cnt_d;

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bbt_back.sv @@
// Back of the tracker: centre, extents and diagonal of one finished box.
`default_nettype none

module bbt_back
  import bbt_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire q_status_t                           q_stat_i,
  input  wire logic [2*NUM_AXES*COORD_BITS-1:0]    box_i,
  output logic                                     pop_o,
  output logic                                     res_valid_o,
  input  wire logic                                res_ready_i,
  output logic      [NUM_AXES*COORD_BITS-1:0]      res_center_o,
  output logic      [NUM_AXES*COORD_BITS-1:0]      res_extent_o,
  output logic      [COORD_BITS:0]                 res_diag_o
);

  localparam int unsigned RootW = COORD_BITS + 1;
  localparam int unsigned RadW  = 2 * RootW;
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned RcntW = $clog2(RootW);
  localparam int unsigned ProdW = 2 * COORD_BITS;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SQUARE = 4'b0010,
    S_ROOT   = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [COORD_BITS-1:0]       ext_q [NUM_AXES];
  logic [COORD_BITS-1:0]       ctr_q [NUM_AXES];
  logic [AXIS_CNT_W-1:0]       sq_cnt_q;
  logic [ProdW-1:0]            prod_q;
  logic [RadW-1:0]             acc_q;
  logic [RadW-1:0]             rad_q;
  logic [RemW-1:0]             rem_q;
  logic [RootW-1:0]            root_q;
  logic [RcntW-1:0]            rcnt_q;
  logic                        out_vld_q;
  logic [NUM_AXES*COORD_BITS-1:0] out_ctr_q;
  logic [NUM_AXES*COORD_BITS-1:0] out_ext_q;
  logic [COORD_BITS:0]         out_diag_q;

  logic [COORD_BITS-1:0]       ext_sel;
  logic [RemW-1:0]             rem_sh;
  logic [RemW-1:0]             trial;
  logic                        fits;
  logic                        load_out;
  logic [RadW-1:0]             acc_sum;

  assign pop_o    = (state_q == S_IDLE) && !q_stat_i.empty;
  assign load_out = (state_q == S_DONE) && (!out_vld_q || res_ready_i);

  assign ext_sel = (sq_cnt_q < AXIS_CNT_W'(NUM_AXES)) ? ext_q[sq_cnt_q[AXIS_IDX_W-1:0]] : '0;
  assign acc_sum = acc_q + RadW'(prod_q);

  // One root bit per step: bring down two radicand bits, try subtracting 4r+1.
  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (!q_stat_i.empty) state_d = S_SQUARE;
      S_SQUARE: if (sq_cnt_q == AXIS_CNT_W'(NUM_AXES)) state_d = S_ROOT;
      S_ROOT:   if (rcnt_q == '0) state_d = S_DONE;
      S_DONE:   if (load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        sq_cnt_q <= '0;
        acc_q    <= '0;
        for (int a = 0; a < NUM_AXES; a++) begin
          logic signed [COORD_BITS-1:0] lo;
          logic signed [COORD_BITS-1:0] hi;
          logic signed [COORD_BITS:0]   sum;
          lo       = $signed(box_i[a*COORD_BITS +: COORD_BITS]);
          hi       = $signed(box_i[(NUM_AXES+a)*COORD_BITS +: COORD_BITS]);
          sum      = {lo[COORD_BITS-1], lo} + {hi[COORD_BITS-1], hi};
          ext_q[a] <= hi - lo;
          ctr_q[a] <= sum[COORD_BITS:1];
        end
      end
      S_SQUARE: begin
        // Square of one axis per cycle; the previous square is summed behind it.
        prod_q   <= ProdW'(ext_sel) * ProdW'(ext_sel);
        sq_cnt_q <= sq_cnt_q + 1'b1;
        if (sq_cnt_q != '0) begin
          acc_q <= acc_sum;
        end
        if (sq_cnt_q == AXIS_CNT_W'(NUM_AXES)) begin
          rad_q  <= acc_sum;
          rem_q  <= '0;
          root_q <= '0;
          rcnt_q <= RcntW'(RootW - 1);
        end
      end
      S_ROOT: begin
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        rcnt_q <= rcnt_q - 1'b1;
        if (fits) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      S_DONE: begin
        if (load_out) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            out_ctr_q[a*COORD_BITS +: COORD_BITS] <= ctr_q[a];
            out_ext_q[a*COORD_BITS +: COORD_BITS] <= ext_q[a];
          end
          out_diag_q <= root_q;
        end
      end
      default: begin
        sq_cnt_q <= '0;
      end
    endcase
  end

  assign res_valid_o  = out_vld_q;
  assign res_center_o = out_ctr_q;
  assign res_extent_o = out_ext_q;
  assign res_diag_o   = out_diag_q;

endmodule

`default_nettype wire

@@ rtl/bounding_box_tracker.sv @@
// Top level of the bounding box tracker: front, box queue and back.
//
//   Channel   Dir  Transfer carries
//   point_i   in   coord_x, coord_y, coord_z (signed), last_point
//   result_o  out  center_x/y/z (signed), extent_x/y/z, diagonal
//
// Points are taken one per cycle unless the queue is full; the min/max update
// of the front is a single compare-and-select per axis. A point with
// last_point set closes the box and pushes it into a two-entry queue, and the
// front starts a fresh box in the next cycle. The back works on one box at a
// time: it captures extents and centre, forms the squares on a single shared
// multiplier, runs the bit-serial square root and loads the output register.
// The output register holds a result until it is taken, while the front keeps
// collecting points; the front stalls only when both queue slots hold boxes.
// Reset is asynchronous and active low; it empties the queue and the box.
`default_nettype none

module bounding_box_tracker
  import bbt_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bbt_point_if.sink     point_i,
  bbt_result_if.source  result_o
);

  localparam int unsigned BoxW = 2 * NUM_AXES * COORD_BITS;

  logic                             push;
  logic                             pop;
  q_status_t                        q_stat;
  logic [BoxW-1:0]                  box_in;
  logic [BoxW-1:0]                  box_out;
  logic [NUM_AXES*COORD_BITS-1:0]   coord;
  logic [NUM_AXES*COORD_BITS-1:0]   center;
  logic [NUM_AXES*COORD_BITS-1:0]   extent;

  // Axis order within the packed point and result vectors is x, y, z.
  assign coord = {point_i.coord_z, point_i.coord_y, point_i.coord_x};

  bbt_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_valid_i (point_i.valid),
    .pt_ready_o (point_i.ready),
    .pt_coord_i (coord),
    .pt_last_i  (point_i.last_point),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .box_o      (box_in)
  );

  bbt_queue #(
    .WIDTH (BoxW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (box_in),
    .pop_i  (pop),
    .data_o (box_out),
    .stat_o (q_stat)
  );

  bbt_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .box_i        (box_out),
    .pop_o        (pop),
    .res_valid_o  (result_o.valid),
    .res_ready_i  (result_o.ready),
    .res_center_o (center),
    .res_extent_o (extent),
    .res_diag_o   (result_o.diagonal)
  );

  assign result_o.center_x = center[0*COORD_BITS +: COORD_BITS];
  assign result_o.center_y = center[1*COORD_BITS +: COORD_BITS];
  assign result_o.center_z = center[2*COORD_BITS +: COORD_BITS];
  assign result_o.extent_x = extent[0*COORD_BITS +: COORD_BITS];
  assign result_o.extent_y = extent[1*COORD_BITS +: COORD_BITS];
  assign result_o.extent_z = extent[2*COORD_BITS +: COORD_BITS];

  // A closed box is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("box pushed into a full queue");

  // The back never takes a box from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("box popped from an empty queue");

  // A push into an empty queue with no pop leaves exactly one box behind.
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop && q_stat.empty) |=> (!q_stat.empty && !q_stat.full))
    else $error("queue count wrong after a push");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench of the bounding box tracker: random point meshes checked against a box predictor.
module tb;

  localparam int unsigned CW = 24;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};

  // One point transfer as seen on the input channel.
  typedef struct {
    coord_t c [3];
    bit     last;
  } point_t;

  // One box report as seen on the result channel.
  typedef struct {
    coord_t          center [3];
    logic [CW-1:0]   extent [3];
    logic [CW:0]     diagonal;
  } box_t;

  // How the coordinates of a random mesh are drawn.
  typedef enum int {
    STYLE_FULL,
    STYLE_CLUSTER,
    STYLE_EXTREME
  } mesh_style_e;

  // The scoreboard keeps its own running box. Every accepted point widens it,
  // and a point marked last turns the box into an expected report and then
  // clears it. Reports from the block are matched in order against the queue.
  class bbox_scoreboard;
    coord_t      lo [3];
    coord_t      hi [3];
    bit          empty;
    box_t        pending_boxes [$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_box();
    endfunction

    function void clear_box();
      for (int a = 0; a < 3; a++) begin
        lo[a] = '0;
        hi[a] = '0;
      end
      empty = 1'b1;
    endfunction

    function int unsigned outstanding();
      return pending_boxes.size();
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%0t mismatch: %s", $time, msg);
      end
    endfunction

    // Floor square root, one result bit at a time from the top.
    function logic [CW:0] floor_sqrt(logic [63:0] v);
      logic [CW:0] root;
      logic [CW:0] trial;
      root = '0;
      for (int b = CW; b >= 0; b--) begin
        trial    = root;
        trial[b] = 1'b1;
        if (64'(trial) * 64'(trial) <= v) begin
          root = trial;
        end
      end
      return root;
    endfunction

    function void absorb_point(point_t p);
      box_t               want;
      logic signed [CW:0] sum;
      logic [63:0]        sq;
      for (int a = 0; a < 3; a++) begin
        if (empty) begin
          lo[a] = p.c[a];
          hi[a] = p.c[a];
        end else begin
          if (p.c[a] < lo[a]) lo[a] = p.c[a];
          if (p.c[a] > hi[a]) hi[a] = p.c[a];
        end
      end
      empty = 1'b0;
      if (!p.last) return;
      sq = '0;
      for (int a = 0; a < 3; a++) begin
        // Sign-extended sum; dropping bit 0 is a floor division by two.
        sum            = {lo[a][CW-1], lo[a]} + {hi[a][CW-1], hi[a]};
        want.center[a] = sum[CW:1];
        want.extent[a] = hi[a] - lo[a];
        sq            += 64'(want.extent[a]) * 64'(want.extent[a]);
      end
      want.diagonal = floor_sqrt(sq);
      pending_boxes.push_back(want);
      clear_box();
    endfunction

    function void check_box(box_t got);
      box_t want;
      if (pending_boxes.size() == 0) begin
        fail("result transfer with no box expected");
        return;
      end
      want = pending_boxes.pop_front();
      for (int a = 0; a < 3; a++) begin
        if (got.center[a] !== want.center[a]) begin
          fail($sformatf("center axis %0d: expected %0d, got %0d",
                         a, want.center[a], got.center[a]));
        end
        if (got.extent[a] !== want.extent[a]) begin
          fail($sformatf("extent axis %0d: expected %0d, got %0d",
                         a, want.extent[a], got.extent[a]));
        end
      end
      if (got.diagonal !== want.diagonal) begin
        fail($sformatf("diagonal: expected %0d, got %0d", want.diagonal, got.diagonal));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bbt_point_if  #(.COORD_BITS(CW)) point_if ();
  bbt_result_if #(.COORD_BITS(CW)) result_if ();

  bounding_box_tracker #(
    .COORD_BITS(CW)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_if),
    .result_o(result_if)
  );

  bbox_scoreboard boxes;

  // Sender bookkeeping. valid_up mirrors the valid we have scheduled, so that
  // valid is never lowered and raised again within one time step.
  bit          valid_up;
  int unsigned burst_left;
  int unsigned points_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A generous ceiling: the slowest correct run needs well under a tenth of it.
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  task automatic drop_valid();
    if (valid_up) begin
      point_if.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // Offers one point and returns at the edge where its transfer happens. The
  // sender runs in bursts; between bursts it may idle with valid low, and
  // about a quarter of the bursts follow the previous one with no gap at all.
  task automatic send_point(coord_t x, coord_t y, coord_t z, bit last);
    point_t      p;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        drop_valid();
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    p.c[0] = x;
    p.c[1] = y;
    p.c[2] = z;
    p.last = last;
    point_if.valid      <= 1'b1;
    point_if.coord_x    <= x;
    point_if.coord_y    <= y;
    point_if.coord_z    <= z;
    point_if.last_point <= last;
    valid_up = 1'b1;
    do @(posedge clk_i); while (!point_if.ready);
    boxes.absorb_point(p);
    points_sent++;
  endtask

  // Holds the sender off until every expected box has been reported.
  task automatic wait_for_boxes();
    drop_valid();
    do @(posedge clk_i); while (boxes.outstanding() != 0);
  endtask

  // One mesh of random points; only the final one carries last_point.
  task automatic send_mesh(int unsigned len, mesh_style_e style);
    coord_t base [3];
    coord_t c [3];
    for (int a = 0; a < 3; a++) base[a] = coord_t'($urandom);
    for (int i = 0; i < len; i++) begin
      for (int a = 0; a < 3; a++) begin
        case (style)
          STYLE_FULL: begin
            c[a] = coord_t'($urandom);
          end
          STYLE_CLUSTER: begin
            // Points near a common base; the offset may wrap past the range ends.
            c[a] = base[a] + coord_t'($urandom_range(0, 511)) - coord_t'(256);
          end
          default: begin
            case ($urandom_range(0, 5))
              0:       c[a] = COORD_MIN;
              1:       c[a] = COORD_MAX;
              2:       c[a] = '0;
              3:       c[a] = '1;
              4:       c[a] = coord_t'(1);
              default: c[a] = coord_t'($urandom);
            endcase
          end
        endcase
      end
      send_point(c[0], c[1], c[2], i == len - 1);
    end
  endtask

  // The receiver stalls on a pattern that steps through four modes in turn: always
  // ready, a coin toss, long stalls with short ready windows, rare stalls.
  initial begin
    logic [31:0] rcv_cycle;
    result_if.ready = 1'b0;
    rcv_cycle = '0;
    forever begin
      @(posedge clk_i);
      rcv_cycle++;
      case (rcv_cycle[11:10])
        2'd0:    result_if.ready <= 1'b1;
        2'd1:    result_if.ready <= 1'($urandom_range(0, 1));
        2'd2:    result_if.ready <= (rcv_cycle[5:0] < 6'd8);
        default: result_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Every result transfer is checked against the oldest expected box.
  always @(posedge clk_i) begin : collect_boxes
    box_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got.center[0] = result_if.center_x;
      got.center[1] = result_if.center_y;
      got.center[2] = result_if.center_z;
      got.extent[0] = result_if.extent_x;
      got.extent[1] = result_if.extent_y;
      got.extent[2] = result_if.extent_z;
      got.diagonal  = result_if.diagonal;
      boxes.check_box(got);
    end
  end

  initial begin
    bit          drained_mid;
    int unsigned pick;
    int unsigned len;
    mesh_style_e style;

    rst_ni              = 1'b0;
    point_if.valid      = 1'b0;
    point_if.coord_x    = '0;
    point_if.coord_y    = '0;
    point_if.coord_z    = '0;
    point_if.last_point = 1'b0;
    boxes       = new();
    valid_up    = 1'b0;
    burst_left  = 0;
    points_sent = 0;
    drained_mid = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A first mesh made only of negative points: the zero corners left by
    // reset must not leak into the box.
    send_point(coord_t'(-5), coord_t'(-5), coord_t'(-5), 1'b0);
    send_point(coord_t'(-10), coord_t'(-20), coord_t'(-30), 1'b1);
    // Single point meshes at the range ends report zero extents at once.
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    // The widest possible box: full extents and the largest diagonal, with a
    // centre of minus one half that must floor to minus one.
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
    // Mixed signs, where an odd sum of negative corners floors downward.
    send_point(coord_t'(-3), coord_t'(5), coord_t'(100), 1'b0);
    send_point(coord_t'(0), coord_t'(4), coord_t'(-100), 1'b0);
    send_point(coord_t'(1), coord_t'(-7), coord_t'(0), 1'b1);
    send_point(coord_t'(-1), coord_t'(-1), coord_t'(-1), 1'b0);
    send_point(coord_t'(-2), coord_t'(-2), coord_t'(-2), 1'b1);
    // Alternating bit patterns drive every coordinate bit both ways.
    send_point(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 1'b0);
    send_point(24'hAAAAAA, 24'h555555, 24'hF0F0F0, 1'b1);
    // A later point inside the box must not move either corner.
    send_point(coord_t'(100), coord_t'(100), coord_t'(100), 1'b0);
    send_point(coord_t'(50), coord_t'(200), coord_t'(-50), 1'b0);
    send_point(coord_t'(100), coord_t'(100), coord_t'(100), 1'b1);
    send_point(coord_t'(7), coord_t'(-8), coord_t'(1), 1'b1);
    wait_for_boxes();

    // Random meshes, mostly short, a few long ones.
    while (points_sent < 1000) begin
      if (!drained_mid && points_sent >= 500) begin
        wait_for_boxes();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        len = 1;
      end else if (pick < 65) begin
        len = $urandom_range(2, 8);
      end else if (pick < 95) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(60, 120);
      end
      style = mesh_style_e'($urandom_range(0, 2));
      send_mesh(len, style);
    end
    drop_valid();

    // Let the last boxes drain, then keep running so that the back can
    // show any report that should not exist.
    for (int n = 0; n < 20000 && boxes.outstanding() != 0; n++) @(posedge clk_i);
    repeat (4 * (CW + 7)) @(posedge clk_i);
    if (boxes.outstanding() != 0) begin
      boxes.fail($sformatf("%0d boxes never reported", boxes.outstanding()));
    end

    if (boxes.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
